>>> rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants of the line pixel stepper
// Register indexes, reset values and the command handed from front to back.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int DIM_BITS       = 13;
  localparam int COLOR_BITS     = 32;
  localparam int CFG_IDX_BITS   = 2;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = 2'd1;

  localparam logic [DIM_BITS-1:0] SURFACE_WIDTH_RST  = 13'd640;
  localparam logic [DIM_BITS-1:0] SURFACE_HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    CMD_STEP,
    CMD_START,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      y_is_major;
    logic      major_neg;
    logic      minor_neg;
  } cmd_ctl_t;

endpackage

>>> rtl/lps_if.sv
// ----------------------------------------------------------------------------
// lps_if: request, pixel and register-write channels
// Each channel carries valid, ready and its payload, with source and sink views.
// ----------------------------------------------------------------------------
interface lps_cmd_if
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [COLOR_BITS-1:0]        line_color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, line_color,
                  output ready);
endinterface

interface lps_pix_if
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0]        pixel_color;
  logic                         pixel_valid;
  logic                         on_surface;
  logic                         last_pixel;
  logic                         rejected;

  modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_valid, on_surface,
                  last_pixel, rejected, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, pixel_valid, on_surface,
                  last_pixel, rejected, output ready);
endinterface

interface lps_cfg_if
  import lps_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DIM_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// line_pixel_stepper: Bresenham line rasterizer, one result per request
// Path: a request is written into the command queue, then its result is registered.
// Throughput: one request per cycle while results are taken; a stalled result backs up the queue.
// Reset (synchronous, rst_n low): queue and output empty, line idle, 640 x 480.
// ----------------------------------------------------------------------------
module line_pixel_stepper
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  lps_cmd_if.sink      in_chan,
  lps_pix_if.source    out_chan,
  lps_cfg_if.sink      cfg_chan
);

  localparam int CW    = COORD_BITS;
  localparam int PW    = CW + 1;
  localparam int EW    = CW + 3;
  localparam int CMD_W = $bits(cmd_ctl_t) + 2 * CW + PW + 3 * EW + COLOR_BITS;

  // Surface registers. Write them only while the block is idle; the block does not enforce it.
  logic [DIM_BITS-1:0] surf_w_r, surf_h_r;

  // Front side: classified command for the current request.
  cmd_ctl_t             f_ctl;
  logic signed [CW-1:0] f_major, f_minor;
  logic [PW-1:0]        f_left;
  logic signed [EW-1:0] f_einit, f_einc, f_ediff;
  logic [COLOR_BITS-1:0] f_color;

  // Back side: head of the queue.
  cmd_ctl_t             b_ctl;
  logic signed [CW-1:0] b_major, b_minor;
  logic [PW-1:0]        b_left;
  logic signed [EW-1:0] b_einit, b_einc, b_ediff;
  logic [COLOR_BITS-1:0] b_color;

  logic [CMD_W-1:0] push_data, pop_data;
  logic             q_ready, q_valid, q_pop;

  // Always accept register writes; an unknown index is dropped.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r <= SURFACE_WIDTH_RST;
      surf_h_r <= SURFACE_HEIGHT_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_SURFACE_WIDTH:  surf_w_r <= cfg_chan.data;
        REG_SURFACE_HEIGHT: surf_h_r <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  // Classify the request: step, trivially rejected start, or a new line
  // with its major axis, step signs and initial error term worked out.
  lps_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .mode       (in_chan.mode),
    .x_start    (in_chan.x_start),
    .y_start    (in_chan.y_start),
    .x_end      (in_chan.x_end),
    .y_end      (in_chan.y_end),
    .line_color (in_chan.line_color),
    .surf_w     (surf_w_r),
    .surf_h     (surf_h_r),
    .cmd_ctl    (f_ctl),
    .cmd_major  (f_major),
    .cmd_minor  (f_minor),
    .cmd_left   (f_left),
    .cmd_einit  (f_einit),
    .cmd_einc   (f_einc),
    .cmd_ediff  (f_ediff),
    .cmd_color  (f_color)
  );

  assign push_data = {f_ctl, f_major, f_minor, f_left, f_einit, f_einc, f_ediff, f_color};
  assign {b_ctl, b_major, b_minor, b_left, b_einit, b_einc, b_ediff, b_color} = pop_data;

  // Request ready depends only on queue space, never on the result side.
  assign in_chan.ready = q_ready;

  lps_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_chan.valid),
    .push_ready (q_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (pop_data)
  );

  // Advance the active line and hold each result in the output register
  // until it is taken.
  lps_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .surf_w    (surf_w_r),
    .surf_h    (surf_h_r),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd_ctl   (b_ctl),
    .cmd_major (b_major),
    .cmd_minor (b_minor),
    .cmd_left  (b_left),
    .cmd_einit (b_einit),
    .cmd_einc  (b_einc),
    .cmd_ediff (b_ediff),
    .cmd_color (b_color),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_x     (out_chan.pixel_x),
    .out_y     (out_chan.pixel_y),
    .out_color (out_chan.pixel_color),
    .out_pix   (out_chan.pixel_valid),
    .out_on    (out_chan.on_surface),
    .out_last  (out_chan.last_pixel),
    .out_rej   (out_chan.rejected)
  );

endmodule

>>> rtl/lps_front.sv
// ----------------------------------------------------------------------------
// lps_front: request classifier
// Turns a request into a step, reject or start command with the line set up.
// ----------------------------------------------------------------------------
module lps_front
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           mode,
  input  logic signed [COORD_BITS-1:0]   x_start,
  input  logic signed [COORD_BITS-1:0]   y_start,
  input  logic signed [COORD_BITS-1:0]   x_end,
  input  logic signed [COORD_BITS-1:0]   y_end,
  input  logic [COLOR_BITS-1:0]          line_color,
  input  logic [DIM_BITS-1:0]            surf_w,
  input  logic [DIM_BITS-1:0]            surf_h,
  output cmd_ctl_t                       cmd_ctl,
  output logic signed [COORD_BITS-1:0]   cmd_major,
  output logic signed [COORD_BITS-1:0]   cmd_minor,
  output logic [COORD_BITS:0]            cmd_left,
  output logic signed [COORD_BITS+2:0]   cmd_einit,
  output logic signed [COORD_BITS+2:0]   cmd_einc,
  output logic signed [COORD_BITS+2:0]   cmd_ediff,
  output logic [COLOR_BITS-1:0]          cmd_color
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int EW   = CW + 3;
  localparam int CMPW = ((CW > DIM_BITS) ? CW : DIM_BITS) + 2;

  logic signed [CMPW-1:0] x0e, x1e, y0e, y1e, wl, hl;
  logic signed [DW-1:0]   x0d, x1d, y0d, y1d, dxr, dyr;
  logic [DW-1:0]          adx, ady, dmaj, dmin;
  logic                   x_up, y_up, x_major, reject;
  logic signed [EW-1:0]   einc, edec;

  // Trivial rejection on both endpoints, in a width that holds every bound.
  assign x0e = {{(CMPW-CW){x_start[CW-1]}}, x_start};
  assign x1e = {{(CMPW-CW){x_end[CW-1]}}, x_end};
  assign y0e = {{(CMPW-CW){y_start[CW-1]}}, y_start};
  assign y1e = {{(CMPW-CW){y_end[CW-1]}}, y_end};
  assign wl  = $signed({{(CMPW-DIM_BITS){1'b0}}, surf_w}) - CMPW'(1);
  assign hl  = $signed({{(CMPW-DIM_BITS){1'b0}}, surf_h}) - CMPW'(1);

  assign reject = (x0e < 0 && x1e < 0) || (y0e < 0 && y1e < 0) ||
                  (x0e > wl && x1e > wl) || (y0e > hl && y1e > hl);

  // Deltas and step directions.
  assign x0d  = {x_start[CW-1], x_start};
  assign x1d  = {x_end[CW-1], x_end};
  assign y0d  = {y_start[CW-1], y_start};
  assign y1d  = {y_end[CW-1], y_end};
  assign dxr  = x1d - x0d;
  assign dyr  = y1d - y0d;
  assign x_up = x1d > x0d;
  assign y_up = y1d > y0d;
  assign adx  = x_up ? dxr : -dxr;
  assign ady  = y_up ? dyr : -dyr;

  // A tie makes y the major axis.
  assign x_major = adx > ady;
  assign dmaj    = x_major ? adx : ady;
  assign dmin    = x_major ? ady : adx;

  assign einc = $signed(EW'({dmin, 1'b0}));
  assign edec = $signed(EW'({dmaj, 1'b0}));

  always_comb begin
    cmd_ctl.y_is_major = !x_major;
    cmd_ctl.major_neg  = x_major ? !x_up : !y_up;
    cmd_ctl.minor_neg  = x_major ? !y_up : !x_up;
    if (mode) begin
      cmd_ctl.kind = CMD_STEP;
    end else if (reject) begin
      cmd_ctl.kind = CMD_REJECT;
    end else begin
      cmd_ctl.kind = CMD_START;
    end
  end

  assign cmd_major = x_major ? x_start : y_start;
  assign cmd_minor = x_major ? y_start : x_start;
  assign cmd_left  = dmaj;
  assign cmd_einc  = einc;
  assign cmd_ediff = einc - edec;
  assign cmd_einit = einc - $signed(EW'(dmaj));
  assign cmd_color = line_color;

endmodule

>>> rtl/lps_queue.sv
// ----------------------------------------------------------------------------
// lps_queue: short command queue
// Register queue between classifier and stepper; either side may stall.
// ----------------------------------------------------------------------------
module lps_queue
  import lps_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slot_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  assign push_ready = count_r != CNT_BITS'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/lps_back.sv
// ----------------------------------------------------------------------------
// lps_back: pixel stepper
// Holds the active line, advances it one pixel per step and registers results.
// ----------------------------------------------------------------------------
module lps_back
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [DIM_BITS-1:0]            surf_w,
  input  logic [DIM_BITS-1:0]            surf_h,
  input  logic                           cmd_valid,
  output logic                           cmd_pop,
  input  cmd_ctl_t                       cmd_ctl,
  input  logic signed [COORD_BITS-1:0]   cmd_major,
  input  logic signed [COORD_BITS-1:0]   cmd_minor,
  input  logic [COORD_BITS:0]            cmd_left,
  input  logic signed [COORD_BITS+2:0]   cmd_einit,
  input  logic signed [COORD_BITS+2:0]   cmd_einc,
  input  logic signed [COORD_BITS+2:0]   cmd_ediff,
  input  logic [COLOR_BITS-1:0]          cmd_color,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [COORD_BITS-1:0]   out_x,
  output logic signed [COORD_BITS-1:0]   out_y,
  output logic [COLOR_BITS-1:0]          out_color,
  output logic                           out_pix,
  output logic                           out_on,
  output logic                           out_last,
  output logic                           out_rej
);

  localparam int CW   = COORD_BITS;
  localparam int PW   = CW + 1;
  localparam int EW   = CW + 3;
  localparam int CMPW = ((CW > DIM_BITS) ? CW : DIM_BITS) + 2;

  function automatic logic on_surf(input logic signed [CW-1:0] px,
                                   input logic signed [CW-1:0] py,
                                   input logic [DIM_BITS-1:0]  w,
                                   input logic [DIM_BITS-1:0]  h);
    logic signed [CMPW-1:0] pxe, pye, we, he;
    pxe = {{(CMPW-CW){px[CW-1]}}, px};
    pye = {{(CMPW-CW){py[CW-1]}}, py};
    we  = $signed({{(CMPW-DIM_BITS){1'b0}}, w});
    he  = $signed({{(CMPW-DIM_BITS){1'b0}}, h});
    return (pxe >= 0) && (pxe < we) && (pye >= 0) && (pye < he);
  endfunction

  logic signed [CW-1:0] major_r, major_nxt, minor_r, minor_nxt;
  logic signed [EW-1:0] err_r, err_nxt, einc_r, einc_nxt, ediff_r, ediff_nxt;
  logic [PW-1:0]        left_r, left_nxt;
  logic                 major_neg_r, major_neg_nxt, minor_neg_r, minor_neg_nxt;
  logic                 y_major_r, y_major_nxt, active_r, active_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [CW-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [COLOR_BITS-1:0] out_color_r, out_color_nxt;
  logic                  out_pix_r, out_pix_nxt, out_on_r, out_on_nxt;
  logic                  out_last_r, out_last_nxt, out_rej_r, out_rej_nxt;

  logic signed [CW-1:0]  major_adv, minor_adv, px, py;
  logic signed [EW-1:0]  err_adv;
  logic                  step_last;

  // Take a command whenever the output register is free or being drained.
  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);

  assign err_adv   = err_r + (err_r[EW-1] ? einc_r : ediff_r);
  assign major_adv = major_neg_r ? major_r - CW'(1) : major_r + CW'(1);
  assign minor_adv = err_r[EW-1] ? minor_r :
                     (minor_neg_r ? minor_r - CW'(1) : minor_r + CW'(1));
  assign step_last = left_r == PW'(1);

  always_comb begin
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    err_nxt       = err_r;
    einc_nxt      = einc_r;
    ediff_nxt     = ediff_r;
    left_nxt      = left_r;
    major_neg_nxt = major_neg_r;
    minor_neg_nxt = minor_neg_r;
    y_major_nxt   = y_major_r;
    active_nxt    = active_r;
    color_nxt     = color_r;
    px            = '0;
    py            = '0;
    out_color_nxt = '0;
    out_pix_nxt   = 1'b0;
    out_last_nxt  = 1'b0;
    out_rej_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd_pop) begin
      out_valid_nxt = 1'b1;
      unique case (cmd_ctl.kind)
        CMD_START: begin
          major_nxt     = cmd_major;
          minor_nxt     = cmd_minor;
          err_nxt       = cmd_einit;
          einc_nxt      = cmd_einc;
          ediff_nxt     = cmd_ediff;
          left_nxt      = cmd_left;
          major_neg_nxt = cmd_ctl.major_neg;
          minor_neg_nxt = cmd_ctl.minor_neg;
          y_major_nxt   = cmd_ctl.y_is_major;
          color_nxt     = cmd_color;
          active_nxt    = cmd_left != '0;
          px            = cmd_ctl.y_is_major ? cmd_minor : cmd_major;
          py            = cmd_ctl.y_is_major ? cmd_major : cmd_minor;
          out_color_nxt = cmd_color;
          out_pix_nxt   = 1'b1;
          out_last_nxt  = cmd_left == '0;
        end
        CMD_REJECT: begin
          active_nxt  = 1'b0;
          left_nxt    = '0;
          out_rej_nxt = 1'b1;
        end
        CMD_STEP: begin
          if (active_r) begin
            major_nxt     = major_adv;
            minor_nxt     = minor_adv;
            err_nxt       = err_adv;
            left_nxt      = left_r - PW'(1);
            active_nxt    = !step_last;
            px            = y_major_r ? minor_adv : major_adv;
            py            = y_major_r ? major_adv : minor_adv;
            out_color_nxt = color_r;
            out_pix_nxt   = 1'b1;
            out_last_nxt  = step_last;
          end
        end
        default: begin
        end
      endcase
    end
    out_x_nxt  = px;
    out_y_nxt  = py;
    out_on_nxt = out_pix_nxt && on_surf(px, py, surf_w, surf_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_r     <= major_nxt;
    minor_r     <= minor_nxt;
    err_r       <= err_nxt;
    einc_r      <= einc_nxt;
    ediff_r     <= ediff_nxt;
    left_r      <= left_nxt;
    major_neg_r <= major_neg_nxt;
    minor_neg_r <= minor_neg_nxt;
    y_major_r   <= y_major_nxt;
    color_r     <= color_nxt;
    if (cmd_pop) begin
      out_x_r     <= out_x_nxt;
      out_y_r     <= out_y_nxt;
      out_color_r <= out_color_nxt;
      out_pix_r   <= out_pix_nxt;
      out_on_r    <= out_on_nxt;
      out_last_r  <= out_last_nxt;
      out_rej_r   <= out_rej_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_color = out_color_r;
  assign out_pix   = out_pix_r;
  assign out_on    = out_on_r;
  assign out_last  = out_last_r;
  assign out_rej   = out_rej_r;

endmodule

>>> rtl/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker: port-level checks for the line pixel stepper
// Watches the result channel and reset; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lps_checker
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] pixel_x,
  input logic signed [COORD_BITS-1:0] pixel_y,
  input logic [COLOR_BITS-1:0]        pixel_color,
  input logic                         pixel_valid,
  input logic                         on_surface,
  input logic                         last_pixel,
  input logic                         rejected
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
      $stable(pixel_color) && $stable(pixel_valid) && $stable(last_pixel))
    else $error("result changed while stalled");

  // On-surface and last only travel with an emitted pixel; a rejection carries neither.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (on_surface || last_pixel || rejected) |->
      (pixel_valid != rejected) && !(rejected && (on_surface || last_pixel)))
    else $error("inconsistent result flags");

  // Non-pixel results carry a zero payload.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && pixel_color == '0)
    else $error("non-pixel result with payload");

  // The output is empty right after reset.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind line_pixel_stepper lps_checker #(
  .COORD_BITS (COORD_BITS)
) u_lps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .pixel_x     (out_chan.pixel_x),
  .pixel_y     (out_chan.pixel_y),
  .pixel_color (out_chan.pixel_color),
  .pixel_valid (out_chan.pixel_valid),
  .on_surface  (out_chan.on_surface),
  .last_pixel  (out_chan.last_pixel),
  .rejected    (out_chan.rejected)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the line pixel stepper
// Drives line-start and step requests, mirrors the rasterizer in a local
// predictor and compares every pixel, field by field, in request order.
// ----------------------------------------------------------------------------
module tb_top
  import lps_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS      = COORD_BITS_DEF;
  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int HOLD_CYCLES     = 150;
  localparam int HOLD_AFTER      = 600;
  localparam int N_PHASES        = 7;
  localparam int PHASE_ITEMS     = 185;
  localparam int MAX_STEPS       = 40;
  localparam int MAX_PRINTED     = 50;
  localparam int N_DIRECTED      = 25;

  // request kinds carried in the mode field
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // register indexes past the two surface registers: writes land nowhere
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

  // expected flag nibble of a typed row: {pixel_valid, on_surface, last, rejected}
  localparam logic [3:0] PIX_NONE   = 4'b0000;
  localparam logic [3:0] PIX_REJECT = 4'b0001;
  localparam logic [3:0] PIX_OFF    = 4'b1000;
  localparam logic [3:0] PIX_ON     = 4'b1100;
  localparam logic [3:0] PIX_ON_END = 4'b1110;

  typedef struct {
    logic                         mode;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic [COLOR_BITS-1:0]        color;
  } req_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic                         drawn;
    logic                         on_surf;
    logic                         last;
    logic                         rej;
  } pix_t;

  // typed answer for a request, or none when the predictor decides
  typedef struct {
    bit   typed;
    pix_t want;
  } pending_t;

  typedef struct packed {
    logic                         mode;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic [COLOR_BITS-1:0]        color;
    logic                         typed;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [COLOR_BITS-1:0]        pcolor;
    logic [3:0]                   flags;
  } dir_row_t;

  // Directed rows, run on the reset surface of 640 x 480. Typed answers stand
  // where the result is plain; the rest go to the predictor.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // step while idle: all-zero result, coordinates ignored
    '{MODE_STEP, 16'sh7FFF, 16'sh8000, -16'sd1, 16'sd0, 32'hFFFF_FFFF,
      1'b1, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    // trivial rejects: wholly left, above, right, below
    '{MODE_START, -16'sd5, 16'sd10, -16'sd1, 16'sd200, 32'h0000_0001,
      1'b1, 16'sd0, 16'sd0, 32'h0, PIX_REJECT},
    '{MODE_START, 16'sd10, -16'sd300, 16'sd600, -16'sd1, 32'h0000_0002,
      1'b1, 16'sd0, 16'sd0, 32'h0, PIX_REJECT},
    '{MODE_START, 16'sd640, 16'sd0, 16'sh7FFF, 16'sd479, 32'h0000_0003,
      1'b1, 16'sd0, 16'sd0, 32'h0, PIX_REJECT},
    '{MODE_START, 16'sd0, 16'sd480, 16'sd639, 16'sh7FFF, 32'h0000_0004,
      1'b1, 16'sd0, 16'sd0, 32'h0, PIX_REJECT},
    // single point in the far corner, then a step that finds the line idle
    '{MODE_START, 16'sd639, 16'sd479, 16'sd639, 16'sd479, 32'hFFFF_FFFF,
      1'b1, 16'sd639, 16'sd479, 32'hFFFF_FFFF, PIX_ON_END},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0,
      1'b1, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    // short x-major line run to its end, plus one step past it
    '{MODE_START, 16'sd0, 16'sd0, 16'sd3, 16'sd1, 32'h1234_5678,
      1'b1, 16'sd0, 16'sd0, 32'h1234_5678, PIX_ON},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0,
      1'b1, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    // diagonal tie going up-left: y takes the major axis
    '{MODE_START, 16'sd5, 16'sd5, 16'sd2, 16'sd2, 32'h0000_0000,
      1'b1, 16'sd5, 16'sd5, 32'h0, PIX_ON},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    // restart mid-line with the full coordinate range, off the surface
    '{MODE_START, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'hA5A5_A5A5,
      1'b1, 16'sh8000, 16'sh8000, 32'hA5A5_A5A5, PIX_OFF},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_START, 16'sh7FFF, 16'sd0, 16'sh8000, 16'sd479, 32'h5A5A_5A5A,
      1'b1, 16'sh7FFF, 16'sd0, 32'h5A5A_5A5A, PIX_OFF},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    // steep line entering from above the surface
    '{MODE_START, 16'sd100, -16'sd3, 16'sd98, 16'sd12, 32'h00C0_FFEE,
      1'b1, 16'sd100, -16'sd3, 32'h00C0_FFEE, PIX_OFF},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE},
    '{MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 16'sd0, 16'sd0, 32'h0, PIX_NONE}
  };

  logic clk = 1'b0;
  logic rst_n;

  lps_cmd_if #(.COORD_BITS(COORD_BITS)) req_if ();
  lps_pix_if #(.COORD_BITS(COORD_BITS)) pix_if ();
  lps_cfg_if                            reg_if ();

  line_pixel_stepper #(
    .COORD_BITS (COORD_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if.sink),
    .out_chan (pix_if.source),
    .cfg_chan (reg_if.sink)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Rasterizer mirror: surface registers and the stepping state of one line
  // --------------------------------------------------------------------------
  logic [DIM_BITS-1:0]          surf_w     = SURFACE_WIDTH_RST;
  logic [DIM_BITS-1:0]          surf_h     = SURFACE_HEIGHT_RST;
  logic signed [COORD_BITS-1:0] lead_pos   = '0;  // position on the major axis
  logic signed [COORD_BITS-1:0] side_pos   = '0;  // position on the minor axis
  logic signed [18:0]           err_acc    = '0;
  logic [16:0]                  steps_left = '0;
  logic                         lead_down  = 1'b0;
  logic                         side_down  = 1'b0;
  logic                         y_leads    = 1'b0;
  logic [17:0]                  err_up     = '0;  // twice the minor delta
  logic [17:0]                  err_down   = '0;  // twice the major delta
  logic [COLOR_BITS-1:0]        line_ink   = '0;
  logic                         drawing    = 1'b0;

  pix_t     pixel_q [$];    // pixels still owed by the block, oldest first
  pending_t request_q [$];  // per offered request, a typed answer or none

  int  n_offered  = 0;
  int  n_results  = 0;
  int  n_errors   = 0;
  int  n_starts   = 0;
  int  n_rejects  = 0;
  int  n_pixels   = 0;
  int  n_ends     = 0;
  int  n_settings = 0;
  int  cur_w      = SURFACE_WIDTH_RST;
  int  cur_h      = SURFACE_HEIGHT_RST;
  bit  tx_steady  = 1'b0;
  bit  rx_steady  = 1'b0;
  int  quiet_cycles = 0;

  // Build one emitted pixel; the surface flag uses signed bounds so a zero
  // width or height leaves nothing on the surface.
  function automatic pix_t place_pixel(int px, int py, bit is_end);
    pix_t p;
    int   w;
    int   h;
    w = int'(surf_w);
    h = int'(surf_h);
    p.x       = COORD_BITS'(px);
    p.y       = COORD_BITS'(py);
    p.color   = line_ink;
    p.drawn   = 1'b1;
    p.on_surf = (px >= 0 && px < w && py >= 0 && py < h);
    p.last    = is_end;
    p.rej     = 1'b0;
    return p;
  endfunction

  // Advance the mirror by one accepted request and return the pixel it owes.
  function automatic pix_t trace_pixel(req_t r);
    pix_t p;
    int   x0, y0, x1, y1;
    int   wl, hl, dx, dy;
    p = '{default: '0};
    if (r.mode == MODE_START) begin
      x0 = int'(r.x0);
      y0 = int'(r.y0);
      x1 = int'(r.x1);
      y1 = int'(r.y1);
      wl = int'(surf_w) - 1;
      hl = int'(surf_h) - 1;
      // any start drops the line in progress
      drawing = 1'b0;
      if ((x0 < 0 && x1 < 0) || (y0 < 0 && y1 < 0) ||
          (x0 > wl && x1 > wl) || (y0 > hl && y1 > hl)) begin
        steps_left = '0;
        p.rej = 1'b1;
        return p;
      end
      line_ink = r.color;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      // a tie hands the major axis to y
      y_leads = !(dx > dy);
      if (!y_leads) begin
        steps_left = 17'(dx);
        err_up     = 18'(2 * dy);
        err_down   = 18'(2 * dx);
        lead_pos   = r.x0;
        side_pos   = r.y0;
        lead_down  = !(x1 > x0);
        side_down  = !(y1 > y0);
        err_acc    = 19'(2 * dy - dx);
      end else begin
        steps_left = 17'(dy);
        err_up     = 18'(2 * dx);
        err_down   = 18'(2 * dy);
        lead_pos   = r.y0;
        side_pos   = r.x0;
        lead_down  = !(y1 > y0);
        side_down  = !(x1 > x0);
        err_acc    = 19'(2 * dx - dy);
      end
      drawing = (steps_left != 0);
      return place_pixel(x0, y0, steps_left == 0);
    end
    if (!drawing) begin
      return p;
    end
    if (err_acc >= 0) begin
      err_acc  = err_acc + err_up - err_down;
      side_pos = side_down ? side_pos - COORD_BITS'(1) : side_pos + COORD_BITS'(1);
    end else begin
      err_acc  = err_acc + err_up;
    end
    lead_pos   = lead_down ? lead_pos - COORD_BITS'(1) : lead_pos + COORD_BITS'(1);
    steps_left = steps_left - 17'd1;
    if (steps_left == 0) begin
      drawing = 1'b0;
    end
    if (y_leads) begin
      return place_pixel(int'(side_pos), int'(lead_pos), !drawing);
    end
    return place_pixel(int'(lead_pos), int'(side_pos), !drawing);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_errors < MAX_PRINTED) begin
      $display("MISMATCH %s at %0t: got %0h, want %0h", what, $realtime, got, want);
    end
    n_errors++;
  endtask

  task automatic check_pixel(pix_t got);
    pix_t want;
    if (pixel_q.size() == 0) begin
      report_mismatch("pixel with nothing pending", 32'(got.x), 32'(got.y));
      return;
    end
    want = pixel_q.pop_front();
    if (got.x !== want.x)             report_mismatch("pixel_x", 32'(got.x), 32'(want.x));
    if (got.y !== want.y)             report_mismatch("pixel_y", 32'(got.y), 32'(want.y));
    if (got.color !== want.color)     report_mismatch("pixel_color", got.color, want.color);
    if (got.drawn !== want.drawn)     report_mismatch("pixel_valid", 32'(got.drawn), 32'(want.drawn));
    if (got.on_surf !== want.on_surf) report_mismatch("on_surface", 32'(got.on_surf), 32'(want.on_surf));
    if (got.last !== want.last)       report_mismatch("last_pixel", 32'(got.last), 32'(want.last));
    if (got.rej !== want.rej)         report_mismatch("rejected", 32'(got.rej), 32'(want.rej));
  endtask

  // Watch all three channels at each rising edge. Values read here are the
  // ones settled before the edge, so the order of processes does not matter.
  always @(posedge clk) begin : watch_channels
    pix_t     got;
    pix_t     pred;
    req_t     r;
    pending_t pend;
    if (rst_n) begin
      if (pix_if.valid && pix_if.ready) begin
        got.x       = pix_if.pixel_x;
        got.y       = pix_if.pixel_y;
        got.color   = pix_if.pixel_color;
        got.drawn   = pix_if.pixel_valid;
        got.on_surf = pix_if.on_surface;
        got.last    = pix_if.last_pixel;
        got.rej     = pix_if.rejected;
        check_pixel(got);
        n_results++;
      end
      if (req_if.valid && req_if.ready) begin
        r.mode  = req_if.mode;
        r.x0    = req_if.x_start;
        r.y0    = req_if.y_start;
        r.x1    = req_if.x_end;
        r.y1    = req_if.y_end;
        r.color = req_if.line_color;
        // always advance the mirror, even where the row types its own answer
        pred = trace_pixel(r);
        if (r.mode == MODE_START) n_starts++;
        if (pred.rej) n_rejects++;
        if (pred.drawn) n_pixels++;
        if (pred.last) n_ends++;
        pend = request_q.pop_front();
        pixel_q.push_back(pend.typed ? pend.want : pred);
      end
      if (reg_if.valid && reg_if.ready) begin
        case (reg_if.index)
          REG_SURFACE_WIDTH:  surf_w = reg_if.data;
          REG_SURFACE_HEIGHT: surf_h = reg_if.data;
          default: ;
        endcase
      end
    end
  end

  // Abort if no channel completes a handshake for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready) ||
          (reg_if.valid && reg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d pixels outstanding",
                 WATCHDOG_LIMIT, pixel_q.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel receiver: random stalls per pixel, one long hold-off to back the
  // block up into its input
  // --------------------------------------------------------------------------
  initial begin : pixel_sink
    int wait_cycles;
    bit held;
    held = 1'b0;
    pix_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      wait_cycles = rx_steady ? 0 : $urandom_range(0, 12);
      if (!held && n_results >= HOLD_AFTER) begin
        held        = 1'b1;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        pix_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pix_if.ready <= 1'b1;
      do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request after a random gap and hold it until taken. Valid stays
  // high across back-to-back requests.
  task automatic offer_req(req_t r, bit typed, pix_t want);
    int       gap;
    pending_t pend;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.mode       <= r.mode;
    req_if.x_start    <= r.x0;
    req_if.y_start    <= r.y0;
    req_if.x_end      <= r.x1;
    req_if.y_end      <= r.y1;
    req_if.line_color <= r.color;
    req_if.valid      <= 1'b1;
    pend.typed = typed;
    pend.want  = want;
    request_q.push_back(pend);
    do @(posedge clk); while (!req_if.ready);
    n_offered++;
  endtask

  // Drop valid and wait until every owed pixel is back.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (n_results != n_offered) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= DIM_BITS'(value);
    do @(posedge clk); while (!reg_if.ready);
  endtask

  task automatic set_surface(int w, int h, bit spare);
    write_reg(REG_SURFACE_WIDTH, w);
    write_reg(REG_SURFACE_HEIGHT, h);
    if (spare) begin
      write_reg(REG_SPARE_2, $urandom);
      write_reg(REG_SPARE_3, $urandom);
    end
    reg_if.valid <= 1'b0;
    cur_w = w;
    cur_h = h;
    n_settings++;
  endtask

  function automatic req_t random_req(logic mode);
    req_t r;
    r.mode  = mode;
    r.x0    = COORD_BITS'($urandom);
    r.y0    = COORD_BITS'($urandom);
    r.x1    = COORD_BITS'($urandom);
    r.y1    = COORD_BITS'($urandom);
    r.color = $urandom;
    return r;
  endfunction

  // Coordinate around a surface span, with the edges picked often.
  function automatic logic signed [COORD_BITS-1:0] near_coord(int span);
    int v;
    case ($urandom_range(0, 7))
      0:       v = -1;
      1:       v = span - 1;
      2:       v = span;
      default: v = int'($urandom_range(0, span + 16)) - 8;
    endcase
    return COORD_BITS'(v);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] below_zero();
    return COORD_BITS'(-int'($urandom_range(1, 32768)));
  endfunction

  // Mostly whole lines near the surface followed by their steps; the rest is
  // stray steps, wild starts and starts wholly past one edge.
  task automatic random_phase(int n_items);
    int   issued;
    int   pick;
    int   n_steps;
    int   dx;
    int   dy;
    req_t r;
    pix_t blank;
    blank  = '{default: '0};
    issued = 0;
    while (issued < n_items) begin
      pick = $urandom_range(0, 99);
      r    = random_req(MODE_START);
      if (pick < 75) begin
        r.x0 = near_coord(cur_w);
        r.y0 = near_coord(cur_h);
        if ($urandom_range(0, 3) != 0) begin
          r.x1 = r.x0 + COORD_BITS'(int'($urandom_range(0, 24)) - 12);
          r.y1 = r.y0 + COORD_BITS'(int'($urandom_range(0, 24)) - 12);
        end else begin
          r.x1 = near_coord(cur_w);
          r.y1 = near_coord(cur_h);
        end
        dx = int'(r.x1) - int'(r.x0);
        dy = int'(r.y1) - int'(r.y0);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        n_steps = (dx > dy) ? dx : dy;
        // cap long lines; they get abandoned by the next start
        if (n_steps > MAX_STEPS) n_steps = $urandom_range(1, MAX_STEPS);
        case ($urandom_range(0, 7))
          0:       n_steps = $urandom_range(0, n_steps);
          1:       n_steps = n_steps + $urandom_range(1, 2);
          default: ;
        endcase
      end else if (pick < 85) begin
        r.mode  = MODE_STEP;
        n_steps = 0;
      end else if (pick < 95) begin
        n_steps = $urandom_range(0, 3);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            r.x0 = below_zero();
            r.x1 = below_zero();
          end
          1: begin
            r.y0 = below_zero();
            r.y1 = below_zero();
          end
          2: begin
            r.x0 = COORD_BITS'($urandom_range(cur_w, 32767));
            r.x1 = COORD_BITS'($urandom_range(cur_w, 32767));
          end
          default: begin
            r.y0 = COORD_BITS'($urandom_range(cur_h, 32767));
            r.y1 = COORD_BITS'($urandom_range(cur_h, 32767));
          end
        endcase
        n_steps = $urandom_range(0, 2);
      end
      offer_req(r, 1'b0, blank);
      issued++;
      repeat (n_steps) begin
        offer_req(random_req(MODE_STEP), 1'b0, blank);
        issued++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed table, then random phases over several surfaces
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    dir_row_t row;
    req_t     r;
    pix_t     want;
    int       w;
    int       h;

    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.mode       <= MODE_START;
    req_if.x_start    <= '0;
    req_if.y_start    <= '0;
    req_if.x_end      <= '0;
    req_if.y_end      <= '0;
    req_if.line_color <= '0;
    reg_if.valid      <= 1'b0;
    reg_if.index      <= REG_SURFACE_WIDTH;
    reg_if.data       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table on the reset surface
    for (int i = 0; i < N_DIRECTED; i++) begin
      row          = DIRECTED[i];
      r.mode       = row.mode;
      r.x0         = row.x0;
      r.y0         = row.y0;
      r.x1         = row.x1;
      r.y1         = row.y1;
      r.color      = row.color;
      want.x       = row.px;
      want.y       = row.py;
      want.color   = row.pcolor;
      want.drawn   = row.flags[3];
      want.on_surf = row.flags[2];
      want.last    = row.flags[1];
      want.rej     = row.flags[0];
      offer_req(r, row.typed, want);
    end
    settle();

    // each phase: new surface while idle, then random traffic
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin w = 1;    h = 4096; end
        1:       begin w = 4096; h = 1;    end
        2:       begin w = 0;    h = 0;    end
        3:       begin w = 8191; h = 8191; end
        4:       begin w = 37;   h = 23;   end
        5:       begin w = 4096; h = 4096; end
        default: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
      endcase
      set_surface(w, h, p == 2 || p == 5);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 3 == 2);
      random_phase(PHASE_ITEMS);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_q.size() != 0) begin
      report_mismatch("pixels never delivered", pixel_q.size(), 0);
    end

    $display("Run: %0d requests, %0d line starts (%0d rejected), %0d pixels, %0d line ends",
             n_offered, n_starts, n_rejects, n_pixels, n_ends);
    $display("Surfaces: reset size plus %0d settings, zero and 8191 among them; %0d mismatches",
             n_settings, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> line_pixel_stepper.f
rtl/lps_pkg.sv
rtl/lps_if.sv
rtl/lps_front.sv
rtl/lps_queue.sv
rtl/lps_back.sv
rtl/line_pixel_stepper.sv
rtl/lps_checker.sv
verif/tb_top.sv
